[design/sha1_pkg.sv]
// Shared types, constants and helpers for the SHA-1 byte-stream hasher.
// Depends on nothing; every other design file uses it by scoped names.
package sha1_pkg;

  localparam int unsigned NumWords   = 5;
  localparam int unsigned NumRounds  = 80;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos     = 56;

  typedef logic [31:0] sha1_word_t;
  typedef logic [7:0]  sha1_byte_t;

  localparam sha1_byte_t PadMark = 8'h80;

  // Initial chaining values, index 0 is the most significant digest word.
  localparam sha1_word_t [NumWords-1:0] InitWords = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // Round constants, one for each group of twenty rounds.
  localparam sha1_word_t [3:0] RoundConst = {
    32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
  };

  // Round group codes.
  localparam logic [1:0] PhaseChoose = 2'd0;
  localparam logic [1:0] PhaseParA   = 2'd1;
  localparam logic [1:0] PhaseMaj    = 2'd2;
  localparam logic [1:0] PhaseParB   = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } sha1_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        too_long;
  } sha1_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_FIN,
    S_OUT
  } sha1_state_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic       load_byte;
    sha1_byte_t byte_val;
    logic       do_round;
    logic [1:0] phase;
    logic       fin;
    logic       reinit;
  } sha1_ctrl_t;

endpackage

[design/sha1_window.sv]
// Block buffer and message schedule: a 16-word shift line.
// Depends on sha1_pkg for the control struct and word types.
module sha1_window (
  input  logic                 clk,
  input  sha1_pkg::sha1_ctrl_t ctrl,
  output sha1_pkg::sha1_word_t w_cur
);

  logic [511:0]         win_r;
  logic [511:0]         win_nxt;
  sha1_pkg::sha1_word_t w_new;

  // The oldest word of the window is the word used by the current round.
  assign w_cur = win_r[511:480];

  // Next schedule word from taps t, t+2, t+8 and t+13, rotated left by one.
  always_comb begin
    w_new = win_r[511:480] ^ win_r[447:416] ^ win_r[255:224] ^ win_r[95:64];
    w_new = {w_new[30:0], w_new[31]};
  end

  // Bytes shift in at the bottom; rounds shift out one word at a time.
  always_comb begin
    win_nxt = win_r;
    if (ctrl.load_byte) begin
      win_nxt = {win_r[503:0], ctrl.byte_val};
    end else if (ctrl.do_round) begin
      win_nxt = {win_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

[design/sha1_core.sv]
// Shared SHA-1 round unit with the working variables and chaining words.
// Depends on sha1_pkg for constants, word types and the control struct.
module sha1_core (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  sha1_pkg::sha1_ctrl_t                          ctrl,
  input  sha1_pkg::sha1_word_t                          w_cur,
  output sha1_pkg::sha1_word_t [sha1_pkg::NumWords-1:0] chain
);

  sha1_pkg::sha1_word_t [sha1_pkg::NumWords-1:0] chain_r;
  sha1_pkg::sha1_word_t [sha1_pkg::NumWords-1:0] chain_nxt;
  sha1_pkg::sha1_word_t [sha1_pkg::NumWords-1:0] var_r;
  sha1_pkg::sha1_word_t [sha1_pkg::NumWords-1:0] var_nxt;
  sha1_pkg::sha1_word_t                          f_val;
  sha1_pkg::sha1_word_t                          tmp;

  assign chain = chain_r;

  // Round function selected by the round group.
  always_comb begin
    case (ctrl.phase)
      sha1_pkg::PhaseChoose: f_val = (var_r[1] & var_r[2]) | (~var_r[1] & var_r[3]);
      sha1_pkg::PhaseMaj:    f_val = (var_r[1] & var_r[2]) | (var_r[1] & var_r[3])
                                   | (var_r[2] & var_r[3]);
      default:               f_val = var_r[1] ^ var_r[2] ^ var_r[3];
    endcase
    tmp = {var_r[0][26:0], var_r[0][31:27]} + f_val + var_r[4] + w_cur
        + sha1_pkg::RoundConst[ctrl.phase];
  end

  // One round a cycle; the closing add folds the variables into the chain.
  always_comb begin
    chain_nxt = chain_r;
    var_nxt   = var_r;
    if (ctrl.reinit) begin
      chain_nxt = sha1_pkg::InitWords;
      var_nxt   = sha1_pkg::InitWords;
    end else if (ctrl.fin) begin
      for (int i = 0; i < sha1_pkg::NumWords; i++) begin
        chain_nxt[i] = chain_r[i] + var_r[i];
      end
      var_nxt = chain_nxt;
    end else if (ctrl.do_round) begin
      var_nxt[4] = var_r[3];
      var_nxt[3] = var_r[2];
      var_nxt[2] = {var_r[1][1:0], var_r[1][31:2]};
      var_nxt[1] = var_r[0];
      var_nxt[0] = tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= sha1_pkg::InitWords;
      var_r   <= sha1_pkg::InitWords;
    end else begin
      chain_r <= chain_nxt;
      var_r   <= var_nxt;
    end
  end

endmodule

[design/sha1_byte_stream_hasher.sv]
// Bytes are accepted only while the sequencer is idle; a byte that fills a block then
// holds the input off for 80 rounds on the single round unit and one chaining add.
// After the last byte, padding enters one byte a cycle to the block end, then one or two
// compressions, then five words, one a cycle while out_stall is low. Synchronous reset
// (rst_n low) restores the initial chaining words and clears length, position and
// overflow flag, as happens after each digest.
module sha1_byte_stream_hasher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sha1_pkg::sha1_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sha1_pkg::sha1_out_t out_data
);

  sha1_pkg::sha1_state_t state_r;
  sha1_pkg::sha1_state_t state_nxt;
  logic [5:0]            pos_r;
  logic [5:0]            pos_nxt;
  logic [63:0]           len_r;
  logic [63:0]           len_nxt;
  logic                  ovf_r;
  logic                  ovf_nxt;
  logic                  pad_r;
  logic                  pad_nxt;
  logic                  mark_r;
  logic                  mark_nxt;
  logic                  fin_blk_r;
  logic                  fin_blk_nxt;
  logic [6:0]            rnd_r;
  logic [6:0]            rnd_nxt;
  logic [2:0]            idx_r;
  logic [2:0]            idx_nxt;
  logic                  in_acc;
  logic                  out_acc;
  logic [7:0]            pad_byte;
  sha1_pkg::sha1_ctrl_t  ctrl;
  sha1_pkg::sha1_word_t  w_cur;
  sha1_pkg::sha1_word_t [sha1_pkg::NumWords-1:0] chain;

  localparam logic [6:0] LastRound = 7'(sha1_pkg::NumRounds - 1);
  localparam logic [5:0] LastPos   = 6'(sha1_pkg::BlockBytes - 1);
  localparam logic [5:0] LenStart  = 6'(sha1_pkg::LenPos);
  localparam logic [2:0] LastIdx   = 3'(sha1_pkg::NumWords - 1);

  sha1_window u_window (
    .clk   (clk),
    .ctrl  (ctrl),
    .w_cur (w_cur)
  );

  sha1_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .w_cur (w_cur),
    .chain (chain)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha1_pkg::S_IDLE: begin
        if (in_acc) begin
          if (pos_r == LastPos) begin
            state_nxt = sha1_pkg::S_COMP;
          end else if (in_data.last_byte) begin
            state_nxt = sha1_pkg::S_PAD;
          end
        end
      end
      sha1_pkg::S_PAD: begin
        if (pos_r == LastPos) begin
          state_nxt = sha1_pkg::S_COMP;
        end
      end
      sha1_pkg::S_COMP: begin
        if (rnd_r == LastRound) begin
          state_nxt = sha1_pkg::S_FIN;
        end
      end
      sha1_pkg::S_FIN: begin
        if (pad_r && fin_blk_r) begin
          state_nxt = sha1_pkg::S_OUT;
        end else if (pad_r) begin
          state_nxt = sha1_pkg::S_PAD;
        end else begin
          state_nxt = sha1_pkg::S_IDLE;
        end
      end
      sha1_pkg::S_OUT: begin
        if (out_acc && idx_r == LastIdx) begin
          state_nxt = sha1_pkg::S_IDLE;
        end
      end
      default: state_nxt = sha1_pkg::S_IDLE;
    endcase
  end

  // Padding byte: the marker first, then zeros, then the big-endian length.
  always_comb begin
    if (!mark_r) begin
      pad_byte = sha1_pkg::PadMark;
    end else if (fin_blk_r && pos_r >= LenStart) begin
      pad_byte = len_r[{~pos_r[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Handshake and datapath control decoded from the state.
  always_comb begin
    in_stall      = (state_r != sha1_pkg::S_IDLE);
    out_valid     = (state_r == sha1_pkg::S_OUT);
    in_acc        = in_valid && !in_stall;
    out_acc       = out_valid && !out_stall;
    ctrl.load_byte = in_acc || (state_r == sha1_pkg::S_PAD);
    ctrl.byte_val  = in_acc ? in_data.data_byte : pad_byte;
    ctrl.do_round  = (state_r == sha1_pkg::S_COMP);
    ctrl.fin       = (state_r == sha1_pkg::S_FIN);
    ctrl.reinit    = out_acc && (idx_r == LastIdx);
    if (rnd_r < 7'd20) begin
      ctrl.phase = sha1_pkg::PhaseChoose;
    end else if (rnd_r < 7'd40) begin
      ctrl.phase = sha1_pkg::PhaseParA;
    end else if (rnd_r < 7'd60) begin
      ctrl.phase = sha1_pkg::PhaseMaj;
    end else begin
      ctrl.phase = sha1_pkg::PhaseParB;
    end
  end

  // Result word, taken straight from the chaining registers.
  always_comb begin
    out_data.digest_word = chain[idx_r];
    out_data.word_index  = idx_r;
    out_data.last_word   = (idx_r == LastIdx);
    out_data.too_long    = ovf_r;
  end

  // Message bookkeeping: position, bit length and padding progress.
  always_comb begin
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    ovf_nxt     = ovf_r;
    pad_nxt     = pad_r;
    mark_nxt    = mark_r;
    fin_blk_nxt = fin_blk_r;
    rnd_nxt     = ctrl.do_round ? rnd_r + 7'd1 : 7'd0;
    idx_nxt     = out_acc ? idx_r + 3'd1 : idx_r;
    if (ctrl.load_byte) begin
      pos_nxt = pos_r + 6'd1;
    end
    if (in_acc) begin
      len_nxt = len_r + 64'd8;
      if (len_nxt == 64'd0) begin
        ovf_nxt = 1'b1;
      end
      if (in_data.last_byte) begin
        pad_nxt = 1'b1;
      end
    end
    // The marker decides whether the length still fits in this block.
    if (state_r == sha1_pkg::S_PAD && !mark_r) begin
      mark_nxt    = 1'b1;
      fin_blk_nxt = (pos_r < LenStart);
    end
    // After an extra padding block the next block carries the length.
    if (ctrl.fin && pad_r) begin
      fin_blk_nxt = fin_blk_r | mark_r;
    end
    if (ctrl.reinit) begin
      pos_nxt     = 6'd0;
      len_nxt     = 64'd0;
      ovf_nxt     = 1'b0;
      pad_nxt     = 1'b0;
      mark_nxt    = 1'b0;
      fin_blk_nxt = 1'b0;
      idx_nxt     = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sha1_pkg::S_IDLE;
      pos_r     <= 6'd0;
      len_r     <= 64'd0;
      ovf_r     <= 1'b0;
      pad_r     <= 1'b0;
      mark_r    <= 1'b0;
      fin_blk_r <= 1'b0;
      rnd_r     <= 7'd0;
      idx_r     <= 3'd0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      len_r     <= len_nxt;
      ovf_r     <= ovf_nxt;
      pad_r     <= pad_nxt;
      mark_r    <= mark_nxt;
      fin_blk_r <= fin_blk_nxt;
      rnd_r     <= rnd_nxt;
      idx_r     <= idx_nxt;
    end
  end

  // A byte that fills the block starts the rounds at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && pos_r == LastPos) |=> (state_r == sha1_pkg::S_COMP && rnd_r == 7'd0))
    else $error("full block did not start compression");

  // Delivering the final word returns the message state to its reset values.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_data.last_word) |=> (pos_r == 6'd0 && len_r == 64'd0 && !ovf_r
                                         && !pad_r && state_r == sha1_pkg::S_IDLE))
    else $error("state not cleared after digest");

  // Padding and digest output only follow a last byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha1_pkg::S_PAD || state_r == sha1_pkg::S_OUT) |-> pad_r)
    else $error("padding or output without a last byte");

  // The digest is only shown once the length has gone into the final block.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (mark_r && fin_blk_r && pos_r == 6'd0))
    else $error("digest shown before the final block");

endmodule
